@@ hw/rtl/light_chaser_step_sequencer_core_defines.svh @@
// Assertion helpers used by the sequencer RTL.
`ifndef LIGHT_CHASER_STEP_SEQUENCER_CORE_DEFINES_SVH
`define LIGHT_CHASER_STEP_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define LCSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcss assertion failed");

// Next-cycle implication, ignored while reset is high.
`define LCSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcss assertion failed");

// Invariant, checked at every edge out of reset.
`define LCSS_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lcss assertion failed");

`endif

@@ hw/rtl/lcss_pkg.sv @@
package lcss_pkg;

  // Request actions
  localparam logic [2:0] ACT_START  = 3'd0;
  localparam logic [2:0] ACT_MANAGE = 3'd1;
  localparam logic [2:0] ACT_ADD    = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_FIND   = 3'd4;

  // Response status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Play direction
  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_PINGPONG = 2'd2;
  localparam logic [1:0] DIR_RANDOM   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_PLAY_MODE      = 1'b0;
  localparam logic CFG_PLAY_DIRECTION = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] scene_id;
    logic        step_valid;
    logic        step_done;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        step_started;
    logic [5:0]  result_index;
    logic [15:0] result_scene;
    logic        playing;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic scan_done;
    logic shift;
    logic del_done;
    logic capture;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_read;
    logic go_scan;
    logic is_delete;
    logic scan_hit;
    logic scan_miss;
    logic shift_end;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/lcss_ctrl.sv @@
module lcss_ctrl
  import lcss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (sts.go_read) begin
            state_next = S_READ;
          end else if (sts.go_scan) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: begin
        state_next = S_RDATA;
      end
      S_RDATA: begin
        cmd.capture = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (sts.scan_hit || sts.scan_miss) begin
          cmd.scan_done = 1'b1;
          state_next = (sts.is_delete && sts.scan_hit) ? S_SHIFT : S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          cmd.del_done = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/lcss_dpath.sv @@
module lcss_dpath
  import lcss_pkg::*;
#(
  parameter int MAX_STEPS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  input  req_t       req_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp_data,
  input  cmd_t       cmd,
  output sts_t       sts
);

  localparam int AW = $clog2(MAX_STEPS);
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_STEPS);

  // Configuration
  logic       play_mode;
  logic [1:0] play_direction;

  // Sequencer state
  logic [CW-1:0] entry_count;
  logic [AW-1:0] position;
  logic          is_playing;
  logic          going_back;

  // Working registers
  req_t          req_q;
  logic [CW-1:0] scan_idx;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;
  logic [CW-1:0] shift_idx;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [15:0]   rdata;
  rsp_t          res;

  logic [15:0] mem [MAX_STEPS];

  // Accept-time decode
  logic [CW-1:0] last;
  logic [CW-1:0] p_cl;
  logic [CW-1:0] p_back;
  logic [CW-1:0] p_new;
  logic          pp_back;
  logic [AW-1:0] pos_n;
  logic          play_n;
  logic          gb_n;
  logic          started;
  logic [2:0]    st_acc;
  logic          single;

  logic [31:0] pos_wide;
  logic [31:0] cmp_wide;
  logic [31:0] cnt_wide;

  logic          add_commit;
  logic [AW-1:0] rd_addr;

  assign single = play_mode;
  assign last   = entry_count - CW'(1);
  assign p_cl   = (CW'(position) > last) ? last : CW'(position);
  assign p_back = (p_cl != '0) ? (p_cl - CW'(1)) : last;

  always_comb begin
    pos_n   = position;
    play_n  = is_playing;
    gb_n    = going_back;
    started = 1'b0;
    st_acc  = ST_OK;
    p_new   = p_cl;
    pp_back = going_back || (p_cl >= last);
    case (req_data.action)
      ACT_START: begin
        if (entry_count == '0) begin
          st_acc = ST_NOT_FOUND;
          play_n = 1'b0;
        end else begin
          pos_n   = (play_direction == DIR_BACKWARD) ? last[AW-1:0] : '0;
          play_n  = 1'b1;
          started = 1'b1;
        end
      end
      ACT_MANAGE: begin
        if (is_playing && (entry_count == '0)) begin
          play_n = 1'b0;
          st_acc = ST_NOT_FOUND;
        end else if (is_playing && req_data.step_done && (play_direction != DIR_RANDOM)) begin
          started = 1'b1;
          case (play_direction)
            DIR_FORWARD: begin
              p_new  = (p_cl >= last) ? '0 : (p_cl + CW'(1));
              play_n = !(single && (p_new == last));
            end
            DIR_BACKWARD: begin
              p_new  = p_back;
              play_n = !(single && (p_new == '0));
            end
            DIR_PINGPONG: begin
              if (!pp_back) begin
                p_new = p_cl + CW'(1);
                gb_n  = (p_new >= last);
              end else begin
                p_new  = p_back;
                gb_n   = (p_new != '0);
                play_n = !(single && (p_new == '0));
              end
            end
            default: begin
              p_new = p_cl;
            end
          endcase
          pos_n = p_new[AW-1:0];
        end
      end
      ACT_ADD: begin
        if (!req_data.step_valid) begin
          st_acc = ST_INVALID;
        end
      end
      default: begin
        st_acc = ST_OK;
      end
    endcase
  end

  assign pos_wide = 32'(pos_n);
  assign cmp_wide = 32'(cmp_idx);
  assign cnt_wide = 32'(entry_count);

  assign sts.go_read   = started;
  assign sts.go_scan   = ((req_data.action == ACT_ADD) && req_data.step_valid)
                         || (req_data.action == ACT_DELETE)
                         || (req_data.action == ACT_FIND);
  assign sts.is_delete = (req_q.action == ACT_DELETE);
  assign sts.scan_hit  = cmp_valid && (rdata == req_q.scene_id);
  assign sts.scan_miss = !cmp_valid && (scan_idx >= entry_count);
  assign sts.shift_end = (shift_idx >= entry_count) && !pend;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  assign add_commit = cmd.scan_done && (req_q.action == ACT_ADD) && !sts.scan_hit
                      && (entry_count != MAX_COUNT);

  always_comb begin
    rd_addr = position;
    if (cmd.scan) begin
      rd_addr = (scan_idx < entry_count) ? scan_idx[AW-1:0] : '0;
    end else if (cmd.shift) begin
      rd_addr = (shift_idx < entry_count) ? shift_idx[AW-1:0] : '0;
    end
  end

  // Scene table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pend) begin
      mem[pend_addr] <= rdata;
    end else if (add_commit) begin
      mem[entry_count[AW-1:0]] <= req_q.scene_id;
    end
    rdata <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode      <= 1'b0;
      play_direction <= DIR_FORWARD;
      entry_count    <= '0;
      position       <= '0;
      is_playing     <= 1'b0;
      going_back     <= 1'b0;
      cmp_valid      <= 1'b0;
      pend           <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLAY_MODE:      play_mode      <= cfg_data[0];
          CFG_PLAY_DIRECTION: play_direction <= cfg_data;
          default:            play_mode      <= play_mode;
        endcase
      end
      if (cmd.accept) begin
        position   <= pos_n;
        is_playing <= play_n;
        going_back <= gb_n;
      end
      if (add_commit) begin
        entry_count <= entry_count + CW'(1);
      end else if (cmd.del_done) begin
        entry_count <= entry_count - CW'(1);
      end
      cmp_valid <= cmd.scan && (scan_idx < entry_count);
      pend      <= cmd.shift && (shift_idx < entry_count);
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q              <= req_data;
      scan_idx           <= '0;
      res.status         <= st_acc;
      res.step_started   <= started;
      res.result_index   <= started ? pos_wide[5:0] : 6'd0;
      res.result_scene   <= 16'd0;
      res.playing        <= play_n;
    end
    if (cmd.scan) begin
      cmp_idx <= scan_idx[AW-1:0];
      if (scan_idx < entry_count) begin
        scan_idx <= scan_idx + CW'(1);
      end
    end
    if (cmd.scan_done) begin
      shift_idx <= CW'(cmp_idx) + CW'(1);
      case (req_q.action)
        ACT_ADD: begin
          if (sts.scan_hit) begin
            res.status <= ST_DUPLICATE;
          end else if (entry_count == MAX_COUNT) begin
            res.status <= ST_FULL;
          end else begin
            res.result_index <= cnt_wide[5:0];
            res.result_scene <= req_q.scene_id;
          end
        end
        default: begin
          if (sts.scan_hit) begin
            res.result_index <= cmp_wide[5:0];
            res.result_scene <= req_q.scene_id;
          end else begin
            res.status <= ST_NOT_FOUND;
          end
        end
      endcase
    end
    if (cmd.shift) begin
      pend_addr <= shift_idx[AW-1:0] - AW'(1);
      if (shift_idx < entry_count) begin
        shift_idx <= shift_idx + CW'(1);
      end
    end
    if (cmd.capture) begin
      res.result_scene <= rdata;
    end
    if (cmd.load_out) begin
      rsp_data <= res;
    end
  end

endmodule

@@ hw/rtl/light_chaser_step_sequencer_core.sv @@
// Lighting chaser step sequencer.
// Requests come in on req_valid / req_stall / req_data; every request yields
// exactly one response on rsp_valid / rsp_stall / rsp_data. A request is taken
// when req_valid is high and req_stall is low; a response is taken when
// rsp_valid is high and rsp_stall is low.
// One request is worked at a time; req_stall stays high from acceptance until
// the response is loaded into the output register. The next request can then
// be taken while that response still waits for the receiver.
// Request flow (acceptance through response load): start or manage that starts
// a step does one scene-table read. Other start/manage, rejected add and unused
// actions go straight to the response load. Add, delete and find scan the table,
// one entry compared per cycle, up to the hit or the end of the table; a delete
// that hits then compacts the entries behind the hit one place down.
// A stalled receiver holds the response register; the block then waits in
// its final step until the register frees up.
// Reset (rst, synchronous) clears entry count, position, play flags and
// configuration; the scene table itself is not cleared and needs no pass.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect next cycle.
`include "light_chaser_step_sequencer_core_defines.svh"

module light_chaser_step_sequencer_core
  import lcss_pkg::*;
#(
  parameter int MAX_STEPS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp_data
);

  // Command and status groups between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // Controller: sequence accept, scene-table read, table scan, compaction and response load
  lcss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: scene table, play state, configuration and response register
  lcss_dpath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // One request at a time: block new requests right after acceptance
  `LCSS_ASSERT_NEXT(a_one_req, clk, rst, req_valid && !req_stall, req_stall)

  // Never overwrite a response that the receiver has not taken
  `LCSS_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.load_out, !rsp_valid || !rsp_stall)

  // A started step always reports success
  `LCSS_ASSERT_IMPLY(a_start_ok, clk, rst, rsp_valid && rsp_data.step_started,
                     rsp_data.status == ST_OK)

  // Controller issues at most one datapath command per cycle
  `LCSS_ASSERT_ALWAYS(a_cmd_onehot, clk, rst, $onehot0(cmd))

endmodule
